[design/tcma_pkg.sv]
// Package for the three-channel moving average block.
// Holds sample and average widths, the stage-1 beat record and shared constants.
// No dependencies.
package tcma_pkg;

  localparam int CH          = 3;
  localparam int LOAD_W      = 14;
  localparam int AVG_W       = 7;
  localparam int SCALE       = 100;
  localparam int AVG_MAX     = 100;
  localparam int LOAD_MAX    = 2 ** LOAD_W - 1;
  localparam int IN_TDATA_W  = ((CH * LOAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CH * AVG_W + 7) / 8) * 8;

  typedef logic [LOAD_W-1:0] load_t;
  typedef load_t [CH-1:0]    load_vec_t;
  typedef logic [AVG_W-1:0]  avg_t;
  typedef avg_t [CH-1:0]     avg_vec_t;

  // Stage-1 beat: new samples, samples leaving the window, and window flags.
  typedef struct packed {
    load_vec_t load_new;
    load_vec_t load_old;
    logic      sub;
    logic      full;
  } s1_t;

endpackage

[design/tcma_hist.sv]
// Sample history ring, write position and warm flag.
// Read-first memory: the slot's old samples come out as the new ones go in.
// Depends on tcma_pkg.
module tcma_hist #(
  parameter int WINDOW = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tcma_pkg::load_vec_t load_i,
  output tcma_pkg::s1_t       s1_o
);
  import tcma_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW - 1);

  load_vec_t        mem [WINDOW];
  load_vec_t        old_q;
  load_vec_t        new_q;
  logic [PTR_W-1:0] wp_q;
  logic [PTR_W-1:0] pos_d;
  logic             warm_q;
  logic             warm_d;
  logic             sub_q;
  logic             full_q;

  assign pos_d  = (wp_q >= LAST) ? '0 : wp_q + PTR_W'(1);
  assign warm_d = warm_q | (pos_d == LAST);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      old_q      <= mem[pos_d];
      mem[pos_d] <= load_i;
      new_q      <= load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= LAST;
      warm_q <= 1'b0;
      sub_q  <= 1'b0;
      full_q <= 1'b0;
    end else if (en_i) begin
      wp_q   <= pos_d;
      warm_q <= warm_d;
      sub_q  <= warm_q;
      full_q <= warm_d;
    end
  end

  assign s1_o.load_new = new_q;
  assign s1_o.load_old = old_q;
  assign s1_o.sub      = sub_q;
  assign s1_o.full     = full_q;

endmodule

[design/tcma_acc.sv]
// Running window sums, one per channel.
// Adds the new sample and drops the outgoing one once the window is warm.
// Depends on tcma_pkg.
module tcma_acc #(
  parameter int SUM_W  = 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  tcma_pkg::s1_t                       s1_i,
  output logic [tcma_pkg::CH-1:0][SUM_W-1:0]  sum_o,
  output logic                                full_o
);
  import tcma_pkg::*;

  logic [CH-1:0][SUM_W-1:0] sum_q;
  logic [CH-1:0][SUM_W-1:0] sum_d;
  logic                     full_q;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      sum_d[c] = sum_q[c] + SUM_W'(s1_i.load_new[c])
               - (s1_i.sub ? SUM_W'(s1_i.load_old[c]) : SUM_W'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      full_q <= 1'b0;
    end else if (en_i) begin
      sum_q  <= sum_d;
      full_q <= s1_i.full;
    end
  end

  assign sum_o  = sum_q;
  assign full_o = full_q;

endmodule

[design/tcma_div.sv]
// Sum to whole-percent average: exact divide by WINDOW*100 via reciprocal
// multiply, then shift, saturate at 100 and zero while filling.
// Depends on tcma_pkg.
module tcma_div #(
  parameter int WINDOW = 25,
  parameter int SUM_W  = 19
) (
  input  logic                               clk_i,
  input  logic                               en3_i,
  input  logic                               en4_i,
  input  logic [tcma_pkg::CH-1:0][SUM_W-1:0] sum_i,
  input  logic                               full_i,
  output tcma_pkg::avg_vec_t                 avg_o,
  output logic                               full_o
);
  import tcma_pkg::*;

  localparam int DIV    = WINDOW * SCALE;
  localparam int SH     = SUM_W + $clog2(DIV);
  localparam int MUL_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam int QW     = PROD_W - SH;
  localparam logic [MUL_W-1:0] MUL =
    MUL_W'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [CH-1:0][PROD_W-1:0] prod_q;
  logic                      full3_q;
  avg_vec_t                  avg_q;
  avg_vec_t                  avg_d;
  logic                      full4_q;
  logic [QW-1:0]             quo;

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      for (int c = 0; c < CH; c++) begin
        prod_q[c] <= PROD_W'(sum_i[c]) * PROD_W'(MUL);
      end
      full3_q <= full_i;
    end
  end

  always_comb begin
    quo = '0;
    for (int c = 0; c < CH; c++) begin
      quo = prod_q[c][PROD_W-1:SH];
      if (!full3_q) begin
        avg_d[c] = '0;
      end else if (32'(quo) > 32'(AVG_MAX)) begin
        avg_d[c] = AVG_W'(AVG_MAX);
      end else begin
        avg_d[c] = AVG_W'(quo);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      avg_q   <= avg_d;
      full4_q <= full3_q;
    end
  end

  assign avg_o  = avg_q;
  assign full_o = full4_q;

endmodule

[design/three_channel_moving_average_top.sv]
// Three-channel moving average: throughput one beat per cycle while the output is not stalled;
// stages are history ring (read-first memory), running sums, reciprocal multiply,
// saturate/output register.
// Output stalls back-pressure the whole pipe through the per-stage valid chain.
// Reset (async, active low) clears sums, warm flag, valids; position -> last slot.
module three_channel_moving_average_top #(
  parameter int WINDOW = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [13:0] load_first, [27:14] load_second, [41:28] load_third, rest zero
  input  logic [tcma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [6:0] avg_first, [13:7] avg_second, [20:14] avg_third, rest zero
  output logic [tcma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] window_full
  output logic                               m_axis_tuser
);
  import tcma_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * LOAD_MAX + 1);

  load_vec_t                loads;
  s1_t                      s1;
  logic [CH-1:0][SUM_W-1:0] sums;
  logic                     full2;
  avg_vec_t                 avgs;
  logic                     full4;
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic                     en1, en2, en3, en4;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      loads[c] = s_axis_tdata[c*LOAD_W +: LOAD_W];
    end
  end

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en1 = s_axis_tvalid && rdy1;
  assign en2 = v1_q && rdy2;
  assign en3 = v2_q && rdy3;
  assign en4 = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  tcma_hist #(.WINDOW(WINDOW)) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en1),
    .load_i (loads),
    .s1_o   (s1)
  );

  tcma_acc #(.SUM_W(SUM_W)) u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en2),
    .s1_i   (s1),
    .sum_o  (sums),
    .full_o (full2)
  );

  tcma_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div (
    .clk_i  (clk_i),
    .en3_i  (en3),
    .en4_i  (en4),
    .sum_i  (sums),
    .full_i (full2),
    .avg_o  (avgs),
    .full_o (full4)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = OUT_TDATA_W'(avgs);
  assign m_axis_tuser  = full4;

endmodule

[design/tcma_chk.sv]
// Port-level checker for the three-channel moving average top, with bind.
// Depends on tcma_pkg and three_channel_moving_average_top.
module tcma_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tcma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import tcma_pkg::*;

  logic       in_beat;
  logic       out_beat;
  logic [3:0] pend_q;
  logic       seen_full_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      seen_full_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 4'(in_beat) - 4'(out_beat);
      if (out_beat && m_axis_tuser) seen_full_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 4'd0)
    else $error("output beat without a pending input beat");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero average while window filling");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[AVG_W-1:0] <= AVG_W'(AVG_MAX)
      && m_axis_tdata[2*AVG_W-1:AVG_W] <= AVG_W'(AVG_MAX)
      && m_axis_tdata[3*AVG_W-1:2*AVG_W] <= AVG_W'(AVG_MAX))
    else $error("average above 100");

  a_stay_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_full_q |-> m_axis_tuser)
    else $error("window_full dropped after being set");

endmodule

bind three_channel_moving_average_top tcma_chk u_tcma_chk (.*);

[tb/tb_three_channel_moving_average_top.sv]
// Testbench for three_channel_moving_average_top: streams load triples in, checks every
// average beat against an in-bench window predictor, under several idle and stall mixes.
// Depends on tcma_pkg and the top module only.
`timescale 1ns / 1ps

module tb_three_channel_moving_average_top;
  import tcma_pkg::*;

  localparam int WINDOW = 25;
  localparam int DIV    = WINDOW * SCALE;

  typedef struct packed {
    avg_vec_t avg;
    logic     full;
  } avg_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  three_channel_moving_average_top #(.WINDOW(WINDOW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // window predictor state
  load_t       load_ring [WINDOW][CH] = '{default: '0};
  int unsigned load_sums [CH]         = '{default: 0};
  int unsigned ring_pos               = WINDOW - 1;
  bit          ring_warm              = 1'b0;

  avg_beat_t avg_expected_q[$];
  avg_beat_t avg_head;
  int        mismatch_count = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;
  int        hold_len       = 0;
  logic      sink_hold      = 1'b0;
  event      hold_trig;

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic avg_beat_t step_window_average(load_vec_t smp);
    avg_beat_t   res;
    int unsigned q;
    ring_pos = (ring_pos + 1 >= WINDOW) ? 0 : ring_pos + 1;
    for (int ch = 0; ch < CH; ch++) begin
      if (ring_warm) load_sums[ch] = load_sums[ch] - load_ring[ring_pos][ch] + smp[ch];
      else load_sums[ch] = load_sums[ch] + smp[ch];
      load_ring[ring_pos][ch] = smp[ch];
    end
    if (!ring_warm && ring_pos == WINDOW - 1) ring_warm = 1'b1;
    res.full = ring_warm;
    for (int ch = 0; ch < CH; ch++) begin
      q = ring_warm ? load_sums[ch] / DIV : 0;
      res.avg[ch] = (q > AVG_MAX) ? avg_t'(AVG_MAX) : avg_t'(q);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // one load beat, with random idle cycles ahead of it
  task automatic send_loads(load_t a, load_t b, load_t c);
    load_vec_t smp;
    smp = {c, b, a};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CH * LOAD_W){1'b0}}, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    avg_expected_q.push_back(step_window_average(smp));
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    go_quiet();
    while (avg_expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic load_t rand_load(int mode);
    case (mode)
      0: return load_t'($urandom_range(10000));
      1: return load_t'($urandom_range(LOAD_MAX));
      2: return load_t'($urandom_range(LOAD_MAX, 10100));
      default: begin
        case ($urandom_range(2))
          0: return load_t'(0);
          1: return load_t'(10000);
          default: return load_t'(LOAD_MAX);
        endcase
      end
    endcase
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 75) return 1;
    if (r < 90) return 2;
    return 3;
  endfunction

  // random loads in chunks; a chunk keeps one value mix per channel so that
  // long high runs push averages into saturation
  task automatic run_random(int n, int src_pct, int snk_pct);
    int m0, m1, m2;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    m0 = 0; m1 = 0; m2 = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        m0 = pick_mode();
        m1 = pick_mode();
        m2 = pick_mode();
      end
      send_loads(rand_load(m0), rand_load(m1), rand_load(m2));
    end
  endtask

  // filling from reset, completing step, wrap of the ring, out-of-range samples
  task automatic test_fill_and_wrap();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < WINDOW; i++) begin
      case (i % 4)
        0: send_loads(load_t'(LOAD_MAX), load_t'(0), load_t'(10000));
        1: send_loads(load_t'(LOAD_MAX), load_t'(10000), load_t'(10000));
        2: send_loads(load_t'(16000), load_t'(0), load_t'(10000));
        default: send_loads(load_t'(LOAD_MAX), load_t'(1), load_t'(9999));
      endcase
    end
    send_loads(load_t'(14'h2AAA), load_t'(14'h1555), load_t'(0));
    send_loads(load_t'(14'h1555), load_t'(14'h2AAA), load_t'(LOAD_MAX));
    send_loads(load_t'(0), load_t'(LOAD_MAX), load_t'(14'h2AAA));
    wait_all_results();
  endtask

  task automatic test_no_idle();
    run_random(200, 0, 0);
    wait_all_results();
  endtask

  task automatic test_sender_idle();
    run_random(200, 69, 0);
    wait_all_results();
  endtask

  task automatic test_receiver_stall();
    run_random(200, 0, 69);
    wait_all_results();
  endtask

  task automatic test_both_idle();
    run_random(200, 31, 31);
    wait_all_results();
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_len = 200;
    -> hold_trig;
    run_random(100, 0, 0);
    wait_all_results();
  endtask

  // sender pauses until the pipe is empty, then resumes
  task automatic test_drain_pause();
    run_random(60, 0, 31);
    wait_all_results();
    run_random(90, 31, 0);
  endtask

  initial forever begin
    @(hold_trig);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (hold_len) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  always @(posedge clk_i)
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (avg_expected_q.size() == 0) begin
        report_mismatch("beat with none pending", int'(m_axis_tdata), 0);
      end else begin
        avg_head = avg_expected_q.pop_front();
        for (int ch = 0; ch < CH; ch++)
          if (m_axis_tdata[ch*AVG_W +: AVG_W] !== avg_head.avg[ch])
            report_mismatch($sformatf("avg ch%0d", ch),
                            int'(m_axis_tdata[ch*AVG_W +: AVG_W]), int'(avg_head.avg[ch]));
        if (m_axis_tdata[OUT_TDATA_W-1:CH*AVG_W] !== '0)
          report_mismatch("tdata pad", int'(m_axis_tdata[OUT_TDATA_W-1:CH*AVG_W]), 0);
        if (m_axis_tuser !== avg_head.full)
          report_mismatch("window_full", int'(m_axis_tuser), int'(avg_head.full));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_wrap();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();
    go_quiet();
    sink_stall_pct = 0;
    for (int i = 0; i < 2000 && avg_expected_q.size() != 0; i++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (avg_expected_q.size() != 0)
      report_mismatch("results never delivered", avg_expected_q.size(), 0);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
